// File: sv/ftw_pkg.sv
// ============================================================================
// ftw_pkg: shared types and constants of the frequency-to-tuning-word bridge
// Holds the step codes of the output sequence, the serial register addresses,
// the divisor of the tuning word division and the queue records.
// ============================================================================
package ftw_pkg;

   localparam int FREQ_W = 32;
   localparam int BYTE_W = 8;

   // Reference clock is 500 MHz = 2^8 * 1953125, so
   // floor(freq * 2^32 / 500e6) == floor(freq * 2^24 / 1953125).
   localparam int DIVISOR_W = 21;
   localparam logic [DIVISOR_W-1:0] DIVISOR = DIVISOR_W'(1953125);

   localparam logic [BYTE_W-1:0] ADDR_CHANNEL_SELECT = 8'h00;
   localparam logic [BYTE_W-1:0] ADDR_TUNING_WORD    = 8'h04;
   localparam logic [BYTE_W-1:0] CSEL_RESET          = 8'h10;

   localparam int QUEUE_DEPTH = 2;

   // One output byte per step; the quotient is formed one byte per step too.
   typedef enum logic [2:0] {
      STEP_ADDR_CSEL  = 3'd0,
      STEP_CSEL_VALUE = 3'd1,
      STEP_ADDR_FTW   = 3'd2,
      STEP_FTW3       = 3'd3,
      STEP_FTW2       = 3'd4,
      STEP_FTW1       = 3'd5,
      STEP_FTW0       = 3'd6
   } step_type;

   typedef struct packed {
      logic              valid;
      logic [FREQ_W-1:0] freq;
   } freq_push_type;

   typedef struct packed {
      logic              valid;
      logic [FREQ_W-1:0] freq;
   } freq_head_type;

endpackage

// File: sv/ftw_front.sv
// ============================================================================
// ftw_front: byte assembler
// Collects four received bytes, least significant first, into one frequency
// and pushes it into the frequency queue.
// ============================================================================
module ftw_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,
   input  logic                  queue_full,
   output ftw_pkg::freq_push_type push
);

   logic [1:0] count_ff, count_in;
   logic [7:0] byte0_ff, byte1_ff, byte2_ff;
   logic       accept;

   // Only the completing byte needs room in the queue.
   assign req_tready = (count_ff != 2'd3) || !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign count_in   = accept ? count_ff + 2'd1 : count_ff;

   assign push.valid = accept && (count_ff == 2'd3);
   assign push.freq  = {req_tdata, byte2_ff, byte1_ff, byte0_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         case (count_ff)
            2'd0:    byte0_ff <= req_tdata;
            2'd1:    byte1_ff <= req_tdata;
            2'd2:    byte2_ff <= req_tdata;
            default: ;
         endcase
      end
   end

endmodule

// File: sv/ftw_queue.sv
// ============================================================================
// ftw_queue: frequency queue
// Short first-in first-out store of assembled frequencies between the byte
// assembler and the tuning word sequencer.
// ============================================================================
module ftw_queue #(
   parameter int Depth = ftw_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ftw_pkg::freq_push_type push,
   output logic                   full,
   output ftw_pkg::freq_head_type head,
   input  logic                   pop
);

   localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CNT_W = $clog2(Depth + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(Depth - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(Depth);

   logic [ftw_pkg::FREQ_W-1:0] store [Depth];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == FULL_CNT);
   assign head.valid = (count_ff != '0);
   assign head.freq  = store[rd_ptr_ff];

   assign do_push = push.valid && !full;
   assign do_pop  = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store[wr_ptr_ff] <= push.freq;
      end
   end

   // The assembler must never offer a frequency the queue cannot take.
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push.valid && full))
      else $error("frequency pushed into a full queue");

   // Occupancy rises by one on a push without a pop.
   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("queue occupancy lost a push");

endmodule

// File: sv/ftw_back.sv
// ============================================================================
// ftw_back: tuning word sequencer
// Divides each frequency into a tuning word one quotient byte per step and
// emits the seven serial bytes through an output register.
// ============================================================================
module ftw_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [7:0]             csr_wr_data,
   input  ftw_pkg::freq_head_type head,
   output logic                   pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,
   output logic                   rsp_tlast
);

   localparam int RW = ftw_pkg::DIVISOR_W;

   logic                       busy_ff, busy_in;
   ftw_pkg::step_type          step_ff, step_in;
   logic [RW-1:0]              rem_ff, rem_in;
   logic [ftw_pkg::FREQ_W-1:0] freq_ff, freq_in;
   logic [7:0]                 csel_ff;
   logic                       out_valid_ff, out_valid_in;
   logic [7:0]                 out_data_ff, out_data_in;
   logic                       out_last_ff, out_last_in;

   logic       advance;
   logic       start;
   logic [7:0] div_byte;
   logic [7:0] digit;
   logic [RW:0] part;
   logic [7:0] emit_byte;

   assign advance = busy_ff && (!out_valid_ff || rsp_tready);
   assign start   = !busy_ff || (advance && (step_ff == ftw_pkg::STEP_FTW0));
   assign pop     = start && head.valid;

   // Dividend is freq followed by three zero bytes, taken most significant first.
   always_comb begin
      case (step_ff)
         ftw_pkg::STEP_ADDR_CSEL:  div_byte = freq_ff[31:24];
         ftw_pkg::STEP_CSEL_VALUE: div_byte = freq_ff[23:16];
         ftw_pkg::STEP_ADDR_FTW:   div_byte = freq_ff[15:8];
         ftw_pkg::STEP_FTW3:       div_byte = freq_ff[7:0];
         default:                  div_byte = 8'd0;
      endcase
   end

   // Eight restoring division steps on the running remainder.
   always_comb begin
      part = {1'b0, rem_ff};
      for (int i = 7; i >= 0; i--) begin
         part = {part[RW-1:0], div_byte[i]};
         if (part >= {1'b0, ftw_pkg::DIVISOR}) begin
            part     = part - {1'b0, ftw_pkg::DIVISOR};
            digit[i] = 1'b1;
         end else begin
            digit[i] = 1'b0;
         end
      end
   end

   always_comb begin
      case (step_ff)
         ftw_pkg::STEP_ADDR_CSEL:  emit_byte = ftw_pkg::ADDR_CHANNEL_SELECT;
         ftw_pkg::STEP_CSEL_VALUE: emit_byte = csel_ff;
         ftw_pkg::STEP_ADDR_FTW:   emit_byte = ftw_pkg::ADDR_TUNING_WORD;
         ftw_pkg::STEP_FTW3,
         ftw_pkg::STEP_FTW2,
         ftw_pkg::STEP_FTW1,
         ftw_pkg::STEP_FTW0:       emit_byte = digit;
         default:                  emit_byte = 8'd0;
      endcase
   end

   always_comb begin
      busy_in      = busy_ff;
      step_in      = step_ff;
      rem_in       = rem_ff;
      freq_in      = freq_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;

      if (advance) begin
         out_valid_in = 1'b1;
         out_data_in  = emit_byte;
         out_last_in  = (step_ff == ftw_pkg::STEP_FTW0);
         rem_in       = part[RW-1:0];
         step_in      = ftw_pkg::step_type'(step_ff + 3'd1);
      end else if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end

      if (pop) begin
         busy_in = 1'b1;
         step_in = ftw_pkg::STEP_ADDR_CSEL;
         rem_in  = '0;
         freq_in = head.freq;
      end else if (advance && (step_ff == ftw_pkg::STEP_FTW0)) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= ftw_pkg::STEP_ADDR_CSEL;
         out_valid_ff <= 1'b0;
         csel_ff      <= ftw_pkg::CSEL_RESET;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            csel_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      freq_ff     <= freq_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   // The final step of a sequence marks its byte as last.
   a_last_on_final_step: assert property (@(posedge clock) disable iff (reset)
      (advance && (step_ff == ftw_pkg::STEP_FTW0)) |=> (rsp_tvalid && rsp_tlast))
      else $error("final tuning word byte not flagged last");

   // A running remainder always stays below the divisor.
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (rem_ff < ftw_pkg::DIVISOR))
      else $error("division remainder out of range");

endmodule

// File: sv/freq_to_dds_tuning_word_bridge_core.sv
// ============================================================================
// freq_to_dds_tuning_word_bridge_core: frequency to tuning word serial bridge
// Assembles four received bytes into a frequency in hertz, converts it into a
// synthesizer tuning word for a 500 MHz reference and emits the serial write
// sequence: channel-select address, channel-select value, tuning word
// address and the word, most significant byte first.
// ============================================================================
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  rx_byte
//   rsp      out        rsp_tvalid/rsp_tready  serial_byte, last_and_update
//   csr      in         csr_wr_en              channel_select_value
//
// Cycles: one input byte is taken per cycle; the fourth byte of a frequency
//   waits only when the frequency queue is full.
// The sequencer emits seven output bytes per frequency, one per cycle while
//   rsp is not stalled, and forms one quotient byte per cycle with an 8-step
//   restoring division; it takes the next frequency as it emits the last
//   byte. Frequencies pass the queue, freq_ff and the output register.
// Reset clears the byte count, the queue, the sequencer and sets the
//   channel-select value to 0x10.
// A stalled rsp holds the sequencer; the queue lets the assembler keep going until it is full.
// ============================================================================
module freq_to_dds_tuning_word_bridge_core #(
   parameter int QueueDepth = ftw_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   // received frequency bytes
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] rx_byte
   // serial write bytes
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] serial_byte
   output logic       rsp_tlast,   // last_and_update
   // channel-select value register
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   ftw_pkg::freq_push_type push;
   ftw_pkg::freq_head_type head;
   logic                   queue_full;
   logic                   pop;

   // Assemble four bytes into one frequency.
   ftw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .queue_full (queue_full),
      .push       (push)
   );

   // Hold frequencies until the sequencer is free.
   ftw_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   // Divide and emit the serial sequence.
   ftw_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .head        (head),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

// File: verif/freq_to_dds_tuning_word_bridge_core_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// Serial write sequence checker
// Watches the byte, result and register channels of the bridge, predicts the
// seven-byte write sequence for every completed frequency and compares each
// returned byte, in order, against the oldest byte still due.
// ============================================================================
module freq_to_dds_tuning_word_bridge_core_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,
   input  logic       rsp_tlast,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   output int         error_count,
   output int         bytes_due,
   output int         bytes_checked
);

   localparam logic [63:0] REF_CLOCK_HZ = 64'd500000000;

   typedef struct packed {
      logic [ftw_pkg::BYTE_W-1:0] serial_byte;
      logic                       last_and_update;
   } serial_write_type;

   serial_write_type           writes_due[$];
   logic [1:0]                 freq_bytes_seen;
   logic [ftw_pkg::BYTE_W-1:0] freq_low_bytes[3];
   logic [ftw_pkg::BYTE_W-1:0] csel_value;
   int                         errors;
   int                         checked;

   initial begin
      errors  = 0;
      checked = 0;
   end

   always @(posedge clock) begin : watch
      logic [ftw_pkg::FREQ_W-1:0] freq_hz;
      logic [63:0]                quotient;
      logic [ftw_pkg::FREQ_W-1:0] word;
      serial_write_type           want;

      if (reset) begin
         writes_due.delete();
         freq_bytes_seen = 2'd0;
         csel_value      = ftw_pkg::CSEL_RESET;
      end else begin
         if (csr_wr_en)
            csel_value = csr_wr_data;

         if (req_tvalid && req_tready) begin
            if (freq_bytes_seen != 2'd3) begin
               freq_low_bytes[freq_bytes_seen] = req_tdata;
               freq_bytes_seen = freq_bytes_seen + 2'd1;
            end else begin
               freq_bytes_seen = 2'd0;
               freq_hz  = {req_tdata, freq_low_bytes[2], freq_low_bytes[1], freq_low_bytes[0]};
               // full-width product, keep the low 32 bits of the quotient
               quotient = {freq_hz, 32'h0} / REF_CLOCK_HZ;
               word     = quotient[31:0];
               writes_due.push_back('{ftw_pkg::ADDR_CHANNEL_SELECT, 1'b0});
               writes_due.push_back('{csel_value, 1'b0});
               writes_due.push_back('{ftw_pkg::ADDR_TUNING_WORD, 1'b0});
               writes_due.push_back('{word[31:24], 1'b0});
               writes_due.push_back('{word[23:16], 1'b0});
               writes_due.push_back('{word[15:8], 1'b0});
               writes_due.push_back('{word[7:0], 1'b1});
            end
         end

         if (rsp_tvalid && rsp_tready) begin
            if (writes_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected serial byte, expected none, got %02h last %0b",
                        $time, rsp_tdata, rsp_tlast);
            end else begin
               want = writes_due.pop_front();
               checked++;
               if (rsp_tdata !== want.serial_byte) begin
                  errors++;
                  $display("%0t: serial byte mismatch, expected %02h, got %02h",
                           $time, want.serial_byte, rsp_tdata);
               end
               if (rsp_tlast !== want.last_and_update) begin
                  errors++;
                  $display("%0t: update flag mismatch, expected %0b, got %0b",
                           $time, want.last_and_update, rsp_tlast);
               end
            end
         end
      end

      error_count   <= errors;
      bytes_due     <= writes_due.size();
      bytes_checked <= checked;
   end

endmodule

// File: verif/freq_to_dds_tuning_word_bridge_core_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// Frequency to tuning word bridge testbench
// Feeds frequencies to the bridge as little-endian byte requests, first a set
// of corner frequencies and then random ones under several channel-select
// settings, with random gaps on both sides, two stretches without gaps and one
// long output hold-off. A checker beside the block predicts and compares.
// ============================================================================
module freq_to_dds_tuning_word_bridge_core_tb;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE_WAIT  = 16;   // block latency plus sequencer margin
   localparam int HOLD_CYCLES  = 150;  // long enough to fill the frequency queue
   localparam int IDLE_PERCENT = 34;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_tvalid  = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata   = 8'h00;
   logic       rsp_tvalid;
   logic       rsp_tready  = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;
   logic       csr_wr_en   = 1'b0;
   logic [7:0] csr_wr_data = 8'h00;

   int error_count;
   int bytes_due;
   int bytes_checked;
   int freqs_sent = 0;
   int cycles     = 0;

   // calm: neither side idles; hold_start: ask the sink for one long hold-off
   bit calm       = 1'b0;
   bit hold_start = 1'b0;

   always #5 clock = ~clock;

   freq_to_dds_tuning_word_bridge_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   freq_to_dds_tuning_word_bridge_core_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .error_count   (error_count),
      .bytes_due     (bytes_due),
      .bytes_checked (bytes_checked)
   );

   // Hard stop in case a handshake never completes.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d serial bytes still due",
                  cycles, bytes_due);
         $display("freq_to_dds_tuning_word_bridge_core verification failed");
         $finish;
      end
   end

   // Output sink: random back-pressure, none while calm, and one counted
   // hold-off when the stimulus asks for it.
   initial begin : sink
      int stall_left;
      bit hold_taken;
      stall_left = 0;
      hold_taken = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_start && !hold_taken) begin
            hold_taken = 1'b1;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (calm) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // Send one frequency as four byte requests, least significant byte first.
   // Valid stays high from one request to the next; it drops only in a gap.
   task automatic send_frequency(input logic [31:0] freq_hz);
      for (int i = 0; i < 4; i++) begin
         while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= freq_hz[8*i +: 8];
         @(posedge clock);
         while (!req_tready) @(posedge clock);
      end
      freqs_sent++;
   endtask

   // Drop valid, wait for every due serial byte, then let the block settle.
   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (bytes_due != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic write_csel(input logic [7:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin : stimulus
      logic [31:0] corner_freqs[6];
      logic [7:0]  csel_settings[4];
      logic [31:0] freq_hz;

      // zero, smallest step, half the clock (word 0x80000000), just below the
      // clock, the clock itself (word wraps to zero) and all ones (wraps)
      corner_freqs  = '{32'd0, 32'd1, 32'd250000000, 32'd499999999,
                        32'd500000000, 32'hFFFF_FFFF};
      csel_settings = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom)};

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Corner frequencies under the reset channel-select value.
      foreach (corner_freqs[i])
         send_frequency(corner_freqs[i]);
      drain();

      // Random frequencies, one phase per channel-select setting. The first
      // and third phases run without idling; the third one holds the output off.
      for (int phase = 0; phase < 4; phase++) begin
         write_csel(csel_settings[phase]);
         calm = (phase == 0 || phase == 2);
         if (phase == 2)
            hold_start = 1'b1;
         repeat (5) begin
            case ($urandom_range(3))
               0:       freq_hz = $urandom;
               1:       freq_hz = $urandom_range(499999999);
               2:       freq_hz = 32'd500000000 + $urandom_range(64) - 32'd32;
               default: for (int b = 0; b < 4; b++)
                           freq_hz[8*b +: 8] = $urandom_range(2) == 0 ? 8'h00 :
                                               $urandom_range(1) == 0 ? 8'hFF :
                                               8'($urandom);
            endcase
            send_frequency(freq_hz);
         end
         drain();
         calm = 1'b0;
      end

      $display("covered %0d frequencies (%0d byte requests), %0d serial bytes checked",
               freqs_sent, 4 * freqs_sent, bytes_checked);
      $display("channel-select reset value, 00, FF and two random values; one %0d-cycle hold-off",
               HOLD_CYCLES);
      if (error_count == 0)
         $display("freq_to_dds_tuning_word_bridge_core verification clean");
      else
         $display("freq_to_dds_tuning_word_bridge_core verification failed");
      $finish;
   end

endmodule
